// ----- hw/rtl/lcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Linear color space converter package
// Shared widths, register and space codes, fixed-point coefficients and the
// decoder that turns a space selection into one coefficient set per channel.
// ----------------------------------------------------------------------------
package lcsc_pkg;

    // Fixed-point format of the coefficients.
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;   // holds +/- 1.0
    localparam int OPND_W         = 10;                   // -255..255 and 0..255
    localparam int PROD_W         = COEF_W + OPND_W;
    localparam int SUM_W          = COEF_FRAC_BITS + 13;
    localparam int INT_W          = SUM_W - COEF_FRAC_BITS;
    localparam int K_W            = COEF_FRAC_BITS + 10;

    // Configuration port.
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int REG_IDX_BIT = 2;
    localparam int SEL_W       = 3;

    typedef enum logic [0:0] {
        REG_SPACE_SELECT = 1'b0,
        REG_DIRECTION    = 1'b1
    } reg_idx_t;

    typedef enum logic [SEL_W-1:0] {
        SPACE_PASS  = 3'd0,
        SPACE_CMY   = 3'd1,
        SPACE_RGGBG = 3'd2,
        SPACE_YUV   = 3'd3,
        SPACE_YDBDR = 3'd4,
        SPACE_YCBCR = 3'd5,
        SPACE_OHTA  = 3'd6
    } space_t;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [INT_W-1:0]  whole_t;
    typedef logic signed [K_W-1:0]    k_t;

    typedef struct packed {
        k_t    k;
        coef_t c0;
        coef_t c1;
        coef_t c2;
        logic  add_one;
        logic  wrap;
    } chan_cfg_t;

    typedef struct packed {
        logic      use_diff;
        chan_cfg_t ch0;
        chan_cfg_t ch1;
        chan_cfg_t ch2;
    } mode_cfg_t;

    // Scale factors.
    localparam longint ONE_L      = longint'(1) << COEF_FRAC_BITS;
    localparam longint HALF_OFF   = longint'(255) << (COEF_FRAC_BITS - 1);
    localparam longint FULL_OFF   = longint'(255) << COEF_FRAC_BITS;
    localparam sum_t   TRUNC_BIAS = sum_t'(ONE_L - 1);

    // Denominators of the decimal coefficients.
    localparam longint D_MILLI = 64'sd1000;
    localparam longint D_MICRO = 64'sd1000000;
    localparam longint D_YUV_U = 64'sd872000;
    localparam longint D_YUV_V = 64'sd1230000;
    localparam longint D_YUV_B = 64'sd100000000;
    localparam longint D_DB    = 64'sd2666;
    localparam longint D_YDB_B = 64'sd1000000000000;
    localparam longint D_YCC   = 64'sd10000000;
    localparam longint D_OHTA  = 64'sd100000;

    // Each coefficient is rounded half away from zero to the fixed-point grid.
    localparam longint Y_R = (64'sd299 * ONE_L + D_MILLI / 2) / D_MILLI;
    localparam longint Y_G = (64'sd587 * ONE_L + D_MILLI / 2) / D_MILLI;
    localparam longint Y_B = (64'sd114 * ONE_L + D_MILLI / 2) / D_MILLI;

    localparam longint YUV_U_R = -((64'sd147130 * ONE_L + D_YUV_U / 2) / D_YUV_U);
    localparam longint YUV_U_G = -((64'sd288860 * ONE_L + D_YUV_U / 2) / D_YUV_U);
    localparam longint YUV_U_B = (64'sd436000 * ONE_L + D_YUV_U / 2) / D_YUV_U;
    localparam longint YUV_V_R = (64'sd615000 * ONE_L + D_YUV_V / 2) / D_YUV_V;
    localparam longint YUV_V_G = -((64'sd514990 * ONE_L + D_YUV_V / 2) / D_YUV_V);
    localparam longint YUV_V_B = -((64'sd100010 * ONE_L + D_YUV_V / 2) / D_YUV_V);

    localparam longint YUVB_R_V = (64'sd113983 * 615 * ONE_L + D_YUV_B / 2) / D_YUV_B;
    localparam longint YUVB_G_U = -((64'sd39465 * 436 * ONE_L + D_YUV_B / 2) / D_YUV_B);
    localparam longint YUVB_G_V = -((64'sd58060 * 615 * ONE_L + D_YUV_B / 2) / D_YUV_B);
    localparam longint YUVB_B_U = (64'sd203211 * 436 * ONE_L + D_YUV_B / 2) / D_YUV_B;

    localparam longint YDB_DB_R = -((64'sd450 * ONE_L + D_DB / 2) / D_DB);
    localparam longint YDB_DB_G = -((64'sd883 * ONE_L + D_DB / 2) / D_DB);
    localparam longint YDB_DB_B = (64'sd1333 * ONE_L + D_DB / 2) / D_DB;
    localparam longint YDB_DR_R = -((64'sd1333 * ONE_L + D_DB / 2) / D_DB);
    localparam longint YDB_DR_G = (64'sd1116 * ONE_L + D_DB / 2) / D_DB;
    localparam longint YDB_DR_B = (64'sd217 * ONE_L + D_DB / 2) / D_DB;

    localparam longint YDBB_R_B =
        (64'sd92304 * 1333 * ONE_L + D_YDB_B / 2) / D_YDB_B;
    localparam longint YDBB_R_R =
        -((64'sd525912631 * 1333 * ONE_L + D_YDB_B / 2) / D_YDB_B);
    localparam longint YDBB_G_B =
        -((64'sd129132899 * 1333 * ONE_L + D_YDB_B / 2) / D_YDB_B);
    localparam longint YDBB_G_R =
        (64'sd267899328 * 1333 * ONE_L + D_YDB_B / 2) / D_YDB_B;
    localparam longint YDBB_B_B =
        (64'sd664679060 * 1333 * ONE_L + D_YDB_B / 2) / D_YDB_B;
    localparam longint YDBB_B_R =
        -((64'sd79203 * 1333 * ONE_L + D_YDB_B / 2) / D_YDB_B);

    localparam longint YCC_Y_R  = (64'sd2988390 * ONE_L + D_YCC / 2) / D_YCC;
    localparam longint YCC_Y_G  = (64'sd5868110 * ONE_L + D_YCC / 2) / D_YCC;
    localparam longint YCC_Y_B  = (64'sd1143500 * ONE_L + D_YCC / 2) / D_YCC;
    localparam longint YCC_CB_R = -((64'sd1687360 * ONE_L + D_YCC / 2) / D_YCC);
    localparam longint YCC_CB_G = -((64'sd3312640 * ONE_L + D_YCC / 2) / D_YCC);
    localparam longint YCC_CB_B = (64'sd5000000 * ONE_L + D_YCC / 2) / D_YCC;
    localparam longint YCC_CR_R = (64'sd5000000 * ONE_L + D_YCC / 2) / D_YCC;
    localparam longint YCC_CR_G = -((64'sd4186880 * ONE_L + D_YCC / 2) / D_YCC);
    localparam longint YCC_CR_B = -((64'sd813120 * ONE_L + D_YCC / 2) / D_YCC);

    localparam longint YCCB_R_CR = (64'sd701 * ONE_L + D_MILLI / 2) / D_MILLI;
    localparam longint YCCB_G_CB = -((64'sd172068 * ONE_L + D_MICRO / 2) / D_MICRO);
    localparam longint YCCB_G_CR = -((64'sd357068 * ONE_L + D_MICRO / 2) / D_MICRO);
    localparam longint YCCB_B_CB = (64'sd886 * ONE_L + D_MILLI / 2) / D_MILLI;

    localparam longint OHTA_I1_RB = (64'sd33333 * ONE_L + D_OHTA / 2) / D_OHTA;
    localparam longint OHTA_I1_G  = (64'sd33334 * ONE_L + D_OHTA / 2) / D_OHTA;
    localparam longint OHTA_HALF  = (ONE_L + 1) / 2;
    localparam longint OHTA_QUART = (ONE_L + 2) / 4;
    localparam longint OHTAB_D3   = -((64'sd33334 * ONE_L + D_OHTA / 2) / D_OHTA);
    localparam longint OHTAB_G_D3 = (64'sd666665 * ONE_L + D_MICRO / 2) / D_MICRO;

    function automatic chan_cfg_t make_chan(
        input longint k,
        input longint c0,
        input longint c1,
        input longint c2,
        input logic   add_one,
        input logic   wrap
    );
        chan_cfg_t cc;
        cc.k       = k_t'(k);
        cc.c0      = coef_t'(c0);
        cc.c1      = coef_t'(c1);
        cc.c2      = coef_t'(c2);
        cc.add_one = add_one;
        cc.wrap    = wrap;
        return cc;
    endfunction

    // Coefficient set for a space and direction. Unused codes pass through.
    function automatic mode_cfg_t mode_cfg(
        input logic [SEL_W-1:0] sel,
        input logic             back
    );
        mode_cfg_t m;
        longint    rg;
        m.use_diff = 1'b0;
        m.ch0      = make_chan(0, ONE_L, 0, 0, 1'b0, 1'b0);
        m.ch1      = make_chan(0, 0, ONE_L, 0, 1'b0, 1'b0);
        m.ch2      = make_chan(0, 0, 0, ONE_L, 1'b0, 1'b0);
        rg         = back ? ONE_L : -ONE_L;
        unique case (space_t'(sel))
            SPACE_PASS:
            begin
                m.use_diff = 1'b0;
            end
            SPACE_CMY:
            begin
                m.ch0 = make_chan(FULL_OFF, -ONE_L, 0, 0, 1'b0, 1'b0);
                m.ch1 = make_chan(FULL_OFF, 0, -ONE_L, 0, 1'b0, 1'b0);
                m.ch2 = make_chan(FULL_OFF, 0, 0, -ONE_L, 1'b0, 1'b0);
            end
            SPACE_RGGBG:
            begin
                m.ch0 = make_chan(0, ONE_L, rg, 0, 1'b0, 1'b1);
                m.ch2 = make_chan(0, 0, rg, ONE_L, 1'b0, 1'b1);
            end
            SPACE_YUV:
            begin
                if (!back)
                begin
                    m.ch0 = make_chan(0, Y_R, Y_G, Y_B, 1'b0, 1'b0);
                    m.ch1 = make_chan(HALF_OFF, YUV_U_R, YUV_U_G, YUV_U_B, 1'b0, 1'b0);
                    m.ch2 = make_chan(HALF_OFF, YUV_V_R, YUV_V_G, YUV_V_B, 1'b0, 1'b0);
                end
                else
                begin
                    m.use_diff = 1'b1;
                    m.ch0 = make_chan(0, ONE_L, 0, YUVB_R_V, 1'b0, 1'b0);
                    m.ch1 = make_chan(0, ONE_L, YUVB_G_U, YUVB_G_V, 1'b0, 1'b0);
                    m.ch2 = make_chan(0, ONE_L, YUVB_B_U, 0, 1'b0, 1'b0);
                end
            end
            SPACE_YDBDR:
            begin
                if (!back)
                begin
                    m.ch0 = make_chan(0, Y_R, Y_G, Y_B, 1'b0, 1'b0);
                    m.ch1 = make_chan(HALF_OFF, YDB_DB_R, YDB_DB_G, YDB_DB_B, 1'b0, 1'b0);
                    m.ch2 = make_chan(HALF_OFF, YDB_DR_R, YDB_DR_G, YDB_DR_B, 1'b0, 1'b0);
                end
                else
                begin
                    m.use_diff = 1'b1;
                    m.ch0 = make_chan(0, ONE_L, YDBB_R_B, YDBB_R_R, 1'b0, 1'b0);
                    m.ch1 = make_chan(0, ONE_L, YDBB_G_B, YDBB_G_R, 1'b0, 1'b0);
                    m.ch2 = make_chan(0, ONE_L, YDBB_B_B, YDBB_B_R, 1'b0, 1'b0);
                end
            end
            SPACE_YCBCR:
            begin
                if (!back)
                begin
                    m.ch0 = make_chan(0, YCC_Y_R, YCC_Y_G, YCC_Y_B, 1'b0, 1'b0);
                    m.ch1 = make_chan(HALF_OFF, YCC_CB_R, YCC_CB_G, YCC_CB_B, 1'b0, 1'b0);
                    m.ch2 = make_chan(HALF_OFF, YCC_CR_R, YCC_CR_G, YCC_CR_B, 1'b0, 1'b0);
                end
                else
                begin
                    m.use_diff = 1'b1;
                    m.ch0 = make_chan(0, ONE_L, 0, YCCB_R_CR, 1'b1, 1'b0);
                    m.ch1 = make_chan(0, ONE_L, YCCB_G_CB, YCCB_G_CR, 1'b0, 1'b0);
                    m.ch2 = make_chan(0, ONE_L, YCCB_B_CB, 0, 1'b1, 1'b0);
                end
            end
            SPACE_OHTA:
            begin
                if (!back)
                begin
                    m.ch0 = make_chan(0, OHTA_I1_RB, OHTA_I1_G, OHTA_I1_RB, 1'b0, 1'b0);
                    m.ch1 = make_chan(HALF_OFF, OHTA_HALF, 0, -OHTA_HALF, 1'b0, 1'b0);
                    m.ch2 = make_chan(HALF_OFF, -OHTA_QUART, OHTA_HALF, -OHTA_QUART,
                                      1'b0, 1'b0);
                end
                else
                begin
                    m.use_diff = 1'b1;
                    m.ch0 = make_chan(0, ONE_L, OHTA_HALF, OHTAB_D3, 1'b0, 1'b0);
                    m.ch1 = make_chan(0, ONE_L, 0, OHTAB_G_D3, 1'b0, 1'b0);
                    m.ch2 = make_chan(0, ONE_L, -OHTA_HALF, OHTAB_D3, 1'b0, 1'b0);
                end
            end
            default:
            begin
                m.use_diff = 1'b0;
            end
        endcase
        return m;
    endfunction

endpackage

// ----- hw/rtl/linear_color_space_converter_core.sv -----
// ----------------------------------------------------------------------------
// Linear color space converter core
// Converts one 8-bit three-channel pixel per clock between RGB and CMY,
// R-GGB-G, YUV, YDbDr, YCbCr or OHTA, in either direction; alpha is carried.
// ----------------------------------------------------------------------------
// Pipeline: a transaction passes the input, product and result registers in
// turn, and done is registered alongside the result.
// Throughput: one transaction per clock; busy is always low, since the
// three-stage pipeline never holds and results cannot be stalled.
// Reset: rst_n clears the pipeline valids and selects passthrough, RGB->space.
// ----------------------------------------------------------------------------
module linear_color_space_converter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [lcsc_pkg::DATA_W-1:0]   pwdata,
    output logic [lcsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Pixel input
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    chan_first,
    input  logic [7:0]                    chan_second,
    input  logic [7:0]                    chan_third,
    input  logic [7:0]                    alpha_in,
    // Pixel result
    output logic                          done,
    output logic [7:0]                    out_first,
    output logic [7:0]                    out_second,
    output logic [7:0]                    out_third,
    output logic [7:0]                    alpha_out
);

    lcsc_pkg::mode_cfg_t mode_cfg;

    // A transaction is taken whenever start is high; the pipeline never
    // has to push back.
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage valids.
    logic v_in_reg;
    logic v_prod_reg;
    logic done_reg;

    // Input register.
    logic [7:0] a_reg;
    logic [7:0] b_reg;
    logic [7:0] c_reg;
    logic [7:0] alpha0_reg;
    logic [7:0] alpha1_reg;
    logic [7:0] alpha2_reg;

    lcsc_pkg::opnd_t x0;
    lcsc_pkg::opnd_t x1;
    lcsc_pkg::opnd_t x2;

    lcsc_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .mode_cfg (mode_cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg   <= 1'b0;
            v_prod_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            v_in_reg   <= accept;
            v_prod_reg <= v_in_reg;
            done_reg   <= v_prod_reg;
        end
    end

    // Payload registers carry no reset; the valids above qualify them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg      <= chan_first;
            b_reg      <= chan_second;
            c_reg      <= chan_third;
            alpha0_reg <= alpha_in;
        end
        if (v_in_reg)
            alpha1_reg <= alpha0_reg;
        if (v_prod_reg)
            alpha2_reg <= alpha1_reg;
    end

    // Operands: the space->RGB linear modes work on the chroma channels as
    // 2x-255, centered on zero; everything else uses the raw bytes.
    assign x0 = lcsc_pkg::opnd_t'({2'b00, a_reg});
    assign x1 = mode_cfg.use_diff
              ? lcsc_pkg::opnd_t'({1'b0, b_reg, 1'b0}) - lcsc_pkg::opnd_t'(255)
              : lcsc_pkg::opnd_t'({2'b00, b_reg});
    assign x2 = mode_cfg.use_diff
              ? lcsc_pkg::opnd_t'({1'b0, c_reg, 1'b0}) - lcsc_pkg::opnd_t'(255)
              : lcsc_pkg::opnd_t'({2'b00, c_reg});

    // One channel unit per output; each holds its product and result stages.
    lcsc_channel u_ch0 (
        .clk     (clk),
        .en_prod (v_in_reg),
        .en_res  (v_prod_reg),
        .x0      (x0),
        .x1      (x1),
        .x2      (x2),
        .cfg     (mode_cfg.ch0),
        .res     (out_first)
    );

    lcsc_channel u_ch1 (
        .clk     (clk),
        .en_prod (v_in_reg),
        .en_res  (v_prod_reg),
        .x0      (x0),
        .x1      (x1),
        .x2      (x2),
        .cfg     (mode_cfg.ch1),
        .res     (out_second)
    );

    lcsc_channel u_ch2 (
        .clk     (clk),
        .en_prod (v_in_reg),
        .en_res  (v_prod_reg),
        .x0      (x0),
        .x1      (x1),
        .x2      (x2),
        .cfg     (mode_cfg.ch2),
        .res     (out_third)
    );

    assign done      = done_reg;
    assign alpha_out = alpha2_reg;

endmodule

// ----- hw/rtl/lcsc_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for the space selection and direction, plus a
// registered decode of the coefficient set used by the datapath.
// ----------------------------------------------------------------------------
module lcsc_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lcsc_pkg::ADDR_W-1:0]      paddr,
    input  logic [lcsc_pkg::DATA_W-1:0]      pwdata,
    output logic [lcsc_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    output lcsc_pkg::mode_cfg_t              mode_cfg
);

    logic [lcsc_pkg::SEL_W-1:0] space_reg;
    logic [lcsc_pkg::SEL_W-1:0] space_next;
    logic                       dir_reg;
    logic                       dir_next;
    lcsc_pkg::mode_cfg_t        cfg_reg;
    lcsc_pkg::reg_idx_t         idx;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = lcsc_pkg::reg_idx_t'(paddr[lcsc_pkg::REG_IDX_BIT]);

    always_comb
    begin
        space_next = space_reg;
        dir_next   = dir_reg;
        if (wr_en)
        begin
            unique case (idx)
                lcsc_pkg::REG_SPACE_SELECT: space_next = pwdata[lcsc_pkg::SEL_W-1:0];
                lcsc_pkg::REG_DIRECTION:    dir_next   = pwdata[0];
                default:                    space_next = space_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lcsc_pkg::REG_SPACE_SELECT:
                prdata = {{(lcsc_pkg::DATA_W - lcsc_pkg::SEL_W){1'b0}}, space_reg};
            lcsc_pkg::REG_DIRECTION:
                prdata = {{(lcsc_pkg::DATA_W - 1){1'b0}}, dir_reg};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_reg <= lcsc_pkg::SPACE_PASS;
            dir_reg   <= 1'b0;
            cfg_reg   <= lcsc_pkg::mode_cfg(lcsc_pkg::SPACE_PASS, 1'b0);
        end
        else
        begin
            space_reg <= space_next;
            dir_reg   <= dir_next;
            // The decode follows the registers in the next cycle.
            cfg_reg   <= lcsc_pkg::mode_cfg(space_reg, dir_reg);
        end
    end

    assign mode_cfg = cfg_reg;

endmodule

// ----- hw/rtl/lcsc_channel.sv -----
// ----------------------------------------------------------------------------
// Converter channel
// Three registered constant products, then offset, truncation toward zero,
// an optional increment and saturation (or byte wrap) into a registered 8-bit result.
// ----------------------------------------------------------------------------
module lcsc_channel (
    input  logic                 clk,
    input  logic                 en_prod,
    input  logic                 en_res,
    input  lcsc_pkg::opnd_t      x0,
    input  lcsc_pkg::opnd_t      x1,
    input  lcsc_pkg::opnd_t      x2,
    input  lcsc_pkg::chan_cfg_t  cfg,
    output logic [7:0]           res
);

    lcsc_pkg::prod_t  p0_reg;
    lcsc_pkg::prod_t  p1_reg;
    lcsc_pkg::prod_t  p2_reg;
    lcsc_pkg::prod_t  p0_next;
    lcsc_pkg::prod_t  p1_next;
    lcsc_pkg::prod_t  p2_next;
    lcsc_pkg::sum_t   sum;
    lcsc_pkg::sum_t   sum_adj;
    lcsc_pkg::whole_t whole;
    lcsc_pkg::whole_t whole_inc;
    logic [7:0]       res_reg;
    logic [7:0]       res_next;

    assign p0_next = lcsc_pkg::prod_t'(cfg.c0) * lcsc_pkg::prod_t'(x0);
    assign p1_next = lcsc_pkg::prod_t'(cfg.c1) * lcsc_pkg::prod_t'(x1);
    assign p2_next = lcsc_pkg::prod_t'(cfg.c2) * lcsc_pkg::prod_t'(x2);

    // Negative sums get a bias so the shift truncates toward zero.
    assign sum     = lcsc_pkg::sum_t'(cfg.k) + lcsc_pkg::sum_t'(p0_reg)
                   + lcsc_pkg::sum_t'(p1_reg) + lcsc_pkg::sum_t'(p2_reg);
    assign sum_adj = sum + (sum[lcsc_pkg::SUM_W-1] ? lcsc_pkg::TRUNC_BIAS : '0);
    assign whole   = sum_adj[lcsc_pkg::SUM_W-1:lcsc_pkg::COEF_FRAC_BITS];
    assign whole_inc = whole + $signed({{(lcsc_pkg::INT_W-1){1'b0}}, cfg.add_one});

    always_comb
    begin
        if (cfg.wrap)
            res_next = whole_inc[7:0];
        else if (whole_inc[lcsc_pkg::INT_W-1])
            res_next = 8'd0;
        else if (|whole_inc[lcsc_pkg::INT_W-2:8])
            res_next = 8'd255;
        else
            res_next = whole_inc[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (en_res)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- hw/rtl/lcsc_checker.sv -----
// ----------------------------------------------------------------------------
// Converter port checker
// Concurrent checks on the top-level ports: fixed latency, alpha transport,
// configuration port readiness and quiet outputs during reset.
// ----------------------------------------------------------------------------
module lcsc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pready,
    input logic                          start,
    input logic                          busy,
    input logic [7:0]                    alpha_in,
    input logic                          done,
    input logic [7:0]                    alpha_out
);

    // Every accepted transaction produces a result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted transaction did not complete after three cycles");

    // No result appears without a matching accepted transaction.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result strobe without a matching transaction");

    // Alpha of a result is the alpha of its transaction.
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (alpha_out == $past(alpha_in, 3)))
        else $error("alpha not carried through");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port not ready");

    // The strobe is unknown until the first reset edge, so it is checked in the
    // cycle after reset is sampled low.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result strobe during reset");

endmodule

bind linear_color_space_converter_core lcsc_checker u_lcsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .start     (start),
    .busy      (busy),
    .alpha_in  (alpha_in),
    .done      (done),
    .alpha_out (alpha_out)
);
